// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the history ring RTL.
// No dependencies; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// File: hw/rtl/mrhr_pkg.sv
// Shared types and constants of the multi-rate history ring.
// No dependencies.
package mrhr_pkg;
  localparam int unsigned MAX_POINTS = 240;
  localparam logic [7:0] MARK_CAP = 8'd255;
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_READ = 1'b1;
  localparam logic [1:0] TIER_FAST = 2'd0;
  localparam logic [1:0] TIER_MID = 2'd1;
  localparam logic [1:0] TIER_SLOW = 2'd2;
  localparam logic [1:0] REG_FAST = 2'd0;
  localparam logic [1:0] REG_MID = 2'd1;
  localparam logic [1:0] REG_SLOW = 2'd2;

  typedef struct packed {
    logic        is_read;
    logic        tier_ok;
    logic [1:0]  tier;
    logic [7:0]  index;
    logic [31:0] epoch;
    logic [15:0] water;
    logic [15:0] air;
    logic [14:0] pressure;
    logic [9:0]  humidity;
    logic [15:0] fan;
  } cmd_t;
endpackage

// File: hw/rtl/mrhr_front.sv
// Front end: accepts items and classifies them into queue commands.
// Depends on mrhr_pkg.
module mrhr_front import mrhr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [31:0] epoch,
  input  logic [15:0] water_temp,
  input  logic [15:0] air_temp,
  input  logic [14:0] pressure,
  input  logic [9:0]  humidity,
  input  logic [15:0] fan_speed,
  input  logic [1:0]  tier_select,
  input  logic [7:0]  point_index,
  output logic        q_valid,
  input  logic        q_ready,
  output cmd_t        q_cmd
);
  // two-entry queue
  cmd_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] level;
  cmd_t       cmd_in;
  logic       push, pop;

  always_comb begin
    cmd_in.is_read  = (command == CMD_READ);
    cmd_in.tier_ok  = (tier_select != 2'd3);
    cmd_in.tier     = tier_select;
    cmd_in.index    = point_index;
    cmd_in.epoch    = epoch;
    cmd_in.water    = water_temp;
    cmd_in.air      = air_temp;
    cmd_in.pressure = pressure;
    cmd_in.humidity = humidity;
    cmd_in.fan      = fan_speed;
  end

  assign in_ready = (level != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (level != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= cmd_in;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      level <= level + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: hw/rtl/mrhr_back.sv
// Back end: tier bookkeeping, ring memories, decimated reads.
// Depends on mrhr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mrhr_back import mrhr_pkg::*; #(
  parameter int FAST_DEPTH = 1024,
  parameter int MID_DEPTH  = 1024,
  parameter int SLOW_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        tier_ok,
  output logic        point_valid,
  output logic [22:0] reported_step,
  output logic [31:0] base_epoch,
  output logic [14:0] stored_count,
  output logic [15:0] out_water,
  output logic [15:0] out_air,
  output logic [14:0] out_pressure,
  output logic [9:0]  out_humidity,
  output logic [15:0] out_fan_speed,
  output logic [7:0]  out_fan_mark
);
  localparam int FAW = $clog2(FAST_DEPTH);
  localparam int MAW = $clog2(MID_DEPTH);
  localparam int SAW = $clog2(SLOW_DEPTH);
  localparam int AW = 14;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ADDR = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [15:0] step [3];
  logic [AW-1:0] wp [3];
  logic [14:0] cnt [3];
  logic [31:0] last_ep [3];
  logic [31:0] old_ep [3];
  logic [14:0] depth [3];
  logic [AW-1:0] depth_m1 [3];

  assign depth[0] = 15'(FAST_DEPTH);
  assign depth[1] = 15'(MID_DEPTH);
  assign depth[2] = 15'(SLOW_DEPTH);
  assign depth_m1[0] = AW'(FAST_DEPTH - 1);
  assign depth_m1[1] = AW'(MID_DEPTH - 1);
  assign depth_m1[2] = AW'(SLOW_DEPTH - 1);

  logic [63:0] f_env [FAST_DEPTH];
  logic [23:0] f_fan [FAST_DEPTH];
  logic [63:0] m_env [MID_DEPTH];
  logic [23:0] m_fan [MID_DEPTH];
  logic [63:0] s_env [SLOW_DEPTH];
  logic [23:0] s_fan [SLOW_DEPTH];

  logic [2:0] state;
  cmd_t cur;
  logic [1:0] tk;
  logic [14:0] rem;
  logic [6:0] stride;
  logic [14:0] offset;
  logic [AW-1:0] pos;
  logic [63:0] rd_env;
  logic [23:0] rd_fan;
  logic rd_valid;

  logic [63:0] env_w;
  logic fan_on;
  logic [2:0] do_store;
  logic [7:0] mark [3];
  logic [AW-1:0] wpn [3];

  assign env_w = {7'd0, cur.humidity, cur.pressure, cur.air, cur.water};
  assign fan_on = (cur.fan != 16'd0) && !cur.fan[15];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      do_store[k] = (last_ep[k] == 32'd0) || ((cur.epoch - last_ep[k]) >= {16'd0, step[k]});
      mark[k] = fan_on ? ((step[k] > {8'd0, MARK_CAP}) ? MARK_CAP : step[k][7:0]) : 8'd0;
      wpn[k] = (wp[k] == depth_m1[k]) ? '0 : wp[k] + 1'b1;
    end
  end

  assign q_ready = (state == S_IDLE);

  logic [14:0] c_sel;
  logic [AW:0] base_sum;
  logic [AW:0] pos_sum;
  assign c_sel = cnt[tk];
  // base = wp - count mod depth; count <= depth, and offset is checked against count
  assign base_sum = {1'b0, wp[tk]} + {1'b0, depth[tk][AW-1:0]} - {1'b0, c_sel[AW-1:0]};

  always_ff @(posedge clk) begin
    if (state == S_DIV && !cur.is_read) begin
      if (do_store[0]) begin
        f_env[wp[0][FAW-1:0]] <= env_w;
        f_fan[wp[0][FAW-1:0]] <= {mark[0], cur.fan};
      end
      if (do_store[1]) begin
        m_env[wp[1][MAW-1:0]] <= env_w;
        m_fan[wp[1][MAW-1:0]] <= {mark[1], cur.fan};
      end
      if (do_store[2]) begin
        s_env[wp[2][SAW-1:0]] <= env_w;
        s_fan[wp[2][SAW-1:0]] <= {mark[2], cur.fan};
      end
    end
    if (state == S_RD) begin
      unique case (tk)
        TIER_FAST: begin
          rd_env <= f_env[pos[FAW-1:0]];
          rd_fan <= f_fan[pos[FAW-1:0]];
        end
        TIER_MID: begin
          rd_env <= m_env[pos[MAW-1:0]];
          rd_fan <= m_fan[pos[MAW-1:0]];
        end
        default: begin
          rd_env <= s_env[pos[SAW-1:0]];
          rd_fan <= s_fan[pos[SAW-1:0]];
        end
      endcase
    end
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      step[0] <= 16'd30;
      step[1] <= 16'd600;
      step[2] <= 16'd7200;
      for (int k = 0; k < 3; k++) begin
        wp[k] <= '0;
        cnt[k] <= '0;
        last_ep[k] <= '0;
        old_ep[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FAST: step[0] <= cfg_data;
          REG_MID:  step[1] <= cfg_data;
          REG_SLOW: step[2] <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_cmd;
            tk <= (q_cmd.tier == 2'd3) ? TIER_SLOW : q_cmd.tier;
            rem <= cnt[(q_cmd.tier == 2'd3) ? TIER_SLOW : q_cmd.tier];
            stride <= 7'd0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!cur.is_read) begin
            for (int k = 0; k < 3; k++) begin
              if (do_store[k]) begin
                wp[k] <= wpn[k];
                last_ep[k] <= cur.epoch;
                if (cnt[k] < depth[k]) begin
                  if (cnt[k] == 15'd0) old_ep[k] <= cur.epoch;
                  cnt[k] <= cnt[k] + 1'b1;
                end else begin
                  old_ep[k] <= old_ep[k] + {16'd0, step[k]};
                end
              end
            end
            state <= S_IDLE;
          end else if (!cur.tier_ok) begin
            state <= S_OUT;
          end else if (rem > 15'(MAX_POINTS)) begin
            // ceil by repeated subtraction
            rem <= rem - 15'(MAX_POINTS);
            stride <= stride + 1'b1;
          end else begin
            stride <= stride + 1'b1;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          offset <= {7'd0, cur.index} * {8'd0, stride};
          state <= S_ADDR;
        end
        S_ADDR: begin
          rd_valid <= (offset < c_sel);
          pos <= AW'(pos_sum);
          state <= S_RD;
        end
        S_RD: state <= S_OUT;
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            tier_ok <= cur.tier_ok;
            point_valid <= cur.tier_ok && rd_valid;
            reported_step <= cur.tier_ok ? ({7'd0, step[tk]} * {16'd0, stride}) : 23'd0;
            base_epoch <= (cur.tier_ok && c_sel != 15'd0) ? old_ep[tk] : 32'd0;
            stored_count <= cur.tier_ok ? c_sel : 15'd0;
            out_water <= (cur.tier_ok && rd_valid) ? rd_env[15:0] : 16'd0;
            out_air <= (cur.tier_ok && rd_valid) ? rd_env[31:16] : 16'd0;
            out_pressure <= (cur.tier_ok && rd_valid) ? rd_env[46:32] : 15'd0;
            out_humidity <= (cur.tier_ok && rd_valid) ? rd_env[56:47] : 10'd0;
            out_fan_speed <= (cur.tier_ok && rd_valid) ? rd_fan[15:0] : 16'd0;
            out_fan_mark <= (cur.tier_ok && rd_valid) ? rd_fan[23:16] : 8'd0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // reduce base and position modulo depth with single subtracts
  logic [AW:0] base_mod;
  logic [AW+1:0] psum;
  assign base_mod = (base_sum >= {1'b0, depth[tk][AW-1:0]}) && (depth[tk] != 15'd16384)
                    ? base_sum - {1'b0, depth[tk][AW-1:0]} : base_sum;
  assign psum = {1'b0, base_mod} + {2'b0, offset[AW-1:0]};
  assign pos_sum = (psum >= {1'b0, depth[tk]}) ? AW'(psum - {1'b0, depth[tk]}) : AW'(psum);

  `ASSERT_IMPL(a_ready_idle, clk, rst, q_ready |-> (state == S_IDLE))
  `ASSERT_NEVER(a_cnt_depth, clk, rst, cnt[0] > depth[0] || cnt[1] > depth[1] || cnt[2] > depth[2])
  `ASSERT_IMPL(a_out_hold, clk, rst, (out_valid && !out_ready) |=> out_valid)
endmodule

// File: hw/rtl/multi_rate_history_ring.sv
// Multi-rate history ring: three sampled tiers with decimated read-back.
// Depends on mrhr_pkg, mrhr_front, mrhr_back.
// A tick writes the rings in the back end's divide state; a read goes through the divide,
// multiply, address, ring read and output states, its stride set by the repeated-subtract
// stride divider. A two-entry queue parts the front end from the back end, and the result
// register holds a read result until it is taken. Ring memories need no clearing pass.
module multi_rate_history_ring import mrhr_pkg::*; #(
  parameter int FAST_DEPTH = 1024,
  parameter int MID_DEPTH  = 1024,
  parameter int SLOW_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [31:0] epoch,
  input  logic signed [15:0] water_temp,
  input  logic signed [15:0] air_temp,
  input  logic [14:0] pressure,
  input  logic [9:0]  humidity,
  input  logic signed [15:0] fan_speed,
  input  logic [1:0]  tier_select,
  input  logic [7:0]  point_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        tier_ok,
  output logic        point_valid,
  output logic [22:0] reported_step,
  output logic [31:0] base_epoch,
  output logic [14:0] stored_count,
  output logic signed [15:0] out_water,
  output logic signed [15:0] out_air,
  output logic [14:0] out_pressure,
  output logic [9:0]  out_humidity,
  output logic signed [15:0] out_fan_speed,
  output logic [7:0]  out_fan_mark
);
  logic q_valid, q_ready;
  cmd_t q_cmd;

  mrhr_front u_front (
    .clk, .rst, .in_valid, .in_ready, .command, .epoch,
    .water_temp(water_temp), .air_temp(air_temp), .pressure, .humidity,
    .fan_speed(fan_speed), .tier_select, .point_index,
    .q_valid, .q_ready, .q_cmd
  );

  mrhr_back #(.FAST_DEPTH(FAST_DEPTH), .MID_DEPTH(MID_DEPTH), .SLOW_DEPTH(SLOW_DEPTH)) u_back (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .q_valid, .q_ready, .q_cmd,
    .out_valid, .out_ready, .tier_ok, .point_valid, .reported_step, .base_epoch,
    .stored_count, .out_water, .out_air, .out_pressure, .out_humidity,
    .out_fan_speed, .out_fan_mark
  );
endmodule
